### hdl/bgr_pkg.sv
// Shared types, constants and font tables for the bitmap glyph rasterizer.
// No dependencies; every other file of the block refers to this package.
package bgr_pkg;

	localparam int CELL_DIM    = 8;
	localparam int ADDR_W      = 17;
	localparam int COLOR_W     = 16;
	localparam int GLYPH_IDX_W = 6;
	localparam int ROW_IDX_W   = 3;
	localparam int PIX_CNT_W   = 6;

	localparam logic [PIX_CNT_W-1:0] LAST_PIX = '1;
	localparam logic [ROW_IDX_W-1:0] LAST_COL = '1;

	// Request word: one character cell
	typedef struct packed {
		logic [5:0]         cell_col;
		logic [4:0]         cell_row;
		logic [7:0]         char_code;
		logic [COLOR_W-1:0] fore_color;
		logic [COLOR_W-1:0] back_color;
	} cell_req_t;

	// Result word: one framebuffer pixel write
	typedef struct packed {
		logic [ADDR_W-1:0]  pixel_addr;
		logic [COLOR_W-1:0] pixel_color;
		logic               last_pixel;
	} pixel_word_t;

	// One pixel issued by the sequencer into the read pipeline
	typedef struct packed {
		logic                   valid;
		logic [GLYPH_IDX_W-1:0] glyph_idx;
		logic [ROW_IDX_W-1:0]   ry;
		logic [ROW_IDX_W-1:0]   cx;
		logic [ADDR_W-1:0]      addr;
		logic [COLOR_W-1:0]     fore;
		logic [COLOR_W-1:0]     back;
		logic                   last;
	} pix_issue_t;

	// Map a character code to its glyph slot; unknown codes take the blank glyph
	function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [7:0] code);
		logic [GLYPH_IDX_W-1:0] idx;
		case (code)
			8'h20:   idx = 6'd0;
			8'h30:   idx = 6'd1;
			8'h31:   idx = 6'd2;
			8'h32:   idx = 6'd3;
			8'h33:   idx = 6'd4;
			8'h34:   idx = 6'd5;
			8'h35:   idx = 6'd6;
			8'h36:   idx = 6'd7;
			8'h37:   idx = 6'd8;
			8'h38:   idx = 6'd9;
			8'h39:   idx = 6'd10;
			8'h41:   idx = 6'd11;
			8'h42:   idx = 6'd12;
			8'h43:   idx = 6'd13;
			8'h44:   idx = 6'd14;
			8'h45:   idx = 6'd15;
			8'h46:   idx = 6'd16;
			8'h47:   idx = 6'd17;
			8'h48:   idx = 6'd18;
			8'h49:   idx = 6'd19;
			8'h4A:   idx = 6'd20;
			8'h4B:   idx = 6'd21;
			8'h4C:   idx = 6'd22;
			8'h4D:   idx = 6'd23;
			8'h4E:   idx = 6'd24;
			8'h4F:   idx = 6'd25;
			8'h50:   idx = 6'd26;
			8'h51:   idx = 6'd27;
			8'h52:   idx = 6'd28;
			8'h53:   idx = 6'd29;
			8'h54:   idx = 6'd30;
			8'h55:   idx = 6'd31;
			8'h56:   idx = 6'd32;
			8'h57:   idx = 6'd33;
			8'h58:   idx = 6'd34;
			8'h59:   idx = 6'd35;
			8'h5A:   idx = 6'd36;
			8'h3D:   idx = 6'd37;
			8'h2D:   idx = 6'd38;
			8'h2E:   idx = 6'd39;
			8'h5F:   idx = 6'd40;
			8'h3A:   idx = 6'd41;
			8'h3E:   idx = 6'd42;
			default: idx = 6'd0;
		endcase
		return idx;
	endfunction

	// Glyph bitmaps, top row in the upper byte, bit 7 of a row is the leftmost pixel
	function automatic logic [63:0] glyph_bits(input logic [GLYPH_IDX_W-1:0] idx);
		logic [63:0] g;
		case (idx)
			6'd1:    g = 64'h70_88_98_A8_C8_88_70_00;
			6'd2:    g = 64'h20_60_20_20_20_20_70_00;
			6'd3:    g = 64'h70_88_10_20_40_80_F8_00;
			6'd4:    g = 64'h70_88_08_30_08_88_70_00;
			6'd5:    g = 64'h10_30_50_90_F8_10_10_00;
			6'd6:    g = 64'hF8_80_F0_08_08_88_70_00;
			6'd7:    g = 64'h70_80_80_F0_88_88_70_00;
			6'd8:    g = 64'hF8_08_10_20_40_40_40_00;
			6'd9:    g = 64'h70_88_88_70_88_88_70_00;
			6'd10:   g = 64'h70_88_88_78_08_08_70_00;
			6'd11:   g = 64'h70_88_88_F8_88_88_88_00;
			6'd12:   g = 64'hF0_88_88_F0_88_88_F0_00;
			6'd13:   g = 64'h70_88_80_80_80_88_70_00;
			6'd14:   g = 64'hF0_88_88_88_88_88_F0_00;
			6'd15:   g = 64'hF8_80_80_F0_80_80_F8_00;
			6'd16:   g = 64'hF8_80_80_F0_80_80_80_00;
			6'd17:   g = 64'h70_88_80_B8_88_88_70_00;
			6'd18:   g = 64'h88_88_88_F8_88_88_88_00;
			6'd19:   g = 64'h70_20_20_20_20_20_70_00;
			6'd20:   g = 64'h38_10_10_10_10_90_60_00;
			6'd21:   g = 64'h88_90_A0_C0_A0_90_88_00;
			6'd22:   g = 64'h80_80_80_80_80_80_F8_00;
			6'd23:   g = 64'h88_D8_A8_A8_88_88_88_00;
			6'd24:   g = 64'h88_C8_C8_A8_98_98_88_00;
			6'd25:   g = 64'h70_88_88_88_88_88_70_00;
			6'd26:   g = 64'hF0_88_88_F0_80_80_80_00;
			6'd27:   g = 64'h70_88_88_88_A8_90_68_00;
			6'd28:   g = 64'hF0_88_88_F0_A0_90_88_00;
			6'd29:   g = 64'h70_88_80_70_08_88_70_00;
			6'd30:   g = 64'hF8_20_20_20_20_20_20_00;
			6'd31:   g = 64'h88_88_88_88_88_88_70_00;
			6'd32:   g = 64'h88_88_88_88_50_50_20_00;
			6'd33:   g = 64'h88_88_88_A8_A8_A8_50_00;
			6'd34:   g = 64'h88_88_50_20_50_88_88_00;
			6'd35:   g = 64'h88_88_50_20_20_20_20_00;
			6'd36:   g = 64'hF8_08_10_20_40_80_F8_00;
			6'd37:   g = 64'h00_00_F8_00_F8_00_00_00;
			6'd38:   g = 64'h00_00_00_F8_00_00_00_00;
			6'd39:   g = 64'h00_00_00_00_00_00_60_00;
			6'd40:   g = 64'h00_00_00_00_00_00_00_F8;
			6'd41:   g = 64'h00_60_60_00_60_60_00_00;
			6'd42:   g = 64'h80_40_20_10_20_40_80_00;
			default: g = 64'h0;
		endcase
		return g;
	endfunction

endpackage

### hdl/bitmap_glyph_rasterizer.sv
// Top level of the bitmap glyph rasterizer: sequencer, font ROM read stage and
// the output register. Depends on bgr_pkg, bgr_cell_seq and bgr_font_rom.
//
// Usage:
//   req channel (req_valid/req_ready/req) takes one character cell word: grid
//   column and row, character code, foreground and background RGB565 colors.
//   pix channel (pix_valid/pix_ready/pix) gives 64 pixel writes per on-grid
//   cell, row-major, leftmost pixel first, last_pixel set on the 64th word.
//   A cell off the grid is accepted and produces nothing.
// Timing:
//   The first pixel of a cell passes from the sequencer registers through the
//   font ROM read register to the output register before it is on pix.
//   One pixel per cycle leaves while pix_ready is high; the pixel counter of
//   the sequencer walks the 64 pixels of a cell. The next request is taken
//   in the cycle the previous cell issues its last pixel.
// Stall and reset:
//   pix_ready low while a word waits on pix freezes the whole pipeline, ROM
//   read port included; no word is lost. Reset clears the sequencer's active
//   flag and pixel count and the valid flags; payload registers are not reset.
module bitmap_glyph_rasterizer #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  bgr_pkg::cell_req_t   req,
	output logic                 pix_valid,
	input  logic                 pix_ready,
	output bgr_pkg::pixel_word_t pix
);

	logic                            en;
	bgr_pkg::pix_issue_t             issue;
	logic                            pix_valid_s1;
	logic [bgr_pkg::ROW_IDX_W-1:0]   cx_s1;
	logic [bgr_pkg::ADDR_W-1:0]      addr_s1;
	logic [bgr_pkg::COLOR_W-1:0]     fore_s1;
	logic [bgr_pkg::COLOR_W-1:0]     back_s1;
	logic                            last_s1;
	logic [7:0]                      row_bits;
	logic                            pix_valid_s2;
	bgr_pkg::pixel_word_t            pix_s2;

	// Advance everything unless a finished word is held
	assign en = !pix_valid_s2 || pix_ready;

	bgr_cell_seq #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.advance  (en),
		.issue    (issue)
	);

	bgr_font_rom u_rom (
		.clk      (clk),
		.en       (en),
		.glyph_idx(issue.glyph_idx),
		.ry       (issue.ry),
		.row_bits (row_bits)
	);

	// Valid flags of the read stage and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
			pix_valid_s2 <= 1'b0;
		end else if (en) begin
			pix_valid_s1 <= issue.valid;
			pix_valid_s2 <= pix_valid_s1;
		end
	end

	// Payload: align pixel data with the ROM word, then pick the color
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1              <= issue.cx;
			addr_s1            <= issue.addr;
			fore_s1            <= issue.fore;
			back_s1            <= issue.back;
			last_s1            <= issue.last;
			pix_s2.pixel_addr  <= addr_s1;
			pix_s2.pixel_color <= row_bits[~cx_s1] ? fore_s1 : back_s1;
			pix_s2.last_pixel  <= last_s1;
		end
	end

	assign pix_valid = pix_valid_s2;
	assign pix       = pix_s2;

endmodule

### hdl/bgr_font_rom.sv
// Synchronous font ROM: one glyph row per read, with the row data registered.
// Depends on bgr_pkg for the glyph bitmaps and index widths.
module bgr_font_rom (
	input  logic                            clk,
	input  logic                            en,
	input  logic [bgr_pkg::GLYPH_IDX_W-1:0] glyph_idx,
	input  logic [bgr_pkg::ROW_IDX_W-1:0]   ry,
	output logic [7:0]                      row_bits
);

	logic [63:0] glyph;
	logic [7:0]  glyph_rows [bgr_pkg::CELL_DIM];
	logic [7:0]  row_q;

	// Split the bitmap into rows, top row first
	always_comb begin
		glyph = bgr_pkg::glyph_bits(glyph_idx);
		for (int r = 0; r < bgr_pkg::CELL_DIM; r++) begin
			glyph_rows[r] = glyph[63 - 8*r -: 8];
		end
	end

	// Registered read port; hold the word while the pipeline stalls
	always_ff @(posedge clk) begin
		if (en) begin
			row_q <= glyph_rows[ry];
		end
	end

	assign row_bits = row_q;

endmodule

### hdl/bgr_cell_seq.sv
// Cell sequencer: takes one request word, checks it against the grid and walks
// its 64 pixels in row-major order. Depends on bgr_pkg.
module bgr_cell_seq #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  bgr_pkg::cell_req_t  req,
	input  logic                advance,
	output bgr_pkg::pix_issue_t issue
);

	localparam int ADDR_W = bgr_pkg::ADDR_W;
	localparam int COLS   = SCREEN_WIDTH / bgr_pkg::CELL_DIM;
	localparam int ROWS   = SCREEN_HEIGHT / bgr_pkg::CELL_DIM;
	localparam logic [ADDR_W-1:0] LINE_STEP  = ADDR_W'(SCREEN_WIDTH);
	localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_WIDTH * bgr_pkg::CELL_DIM);

	logic                                active_q;
	logic [bgr_pkg::PIX_CNT_W-1:0]       k_q;
	logic [bgr_pkg::GLYPH_IDX_W-1:0]     idx_q;
	logic [bgr_pkg::COLOR_W-1:0]         fore_q;
	logic [bgr_pkg::COLOR_W-1:0]         back_q;
	logic [ADDR_W-1:0]                   line_q;
	logic [bgr_pkg::ROW_IDX_W-1:0]       cx;
	logic                                on_grid;
	logic                                accept;
	logic                                last_issue;
	logic [ADDR_W-1:0]                   base;

	assign cx         = k_q[bgr_pkg::ROW_IDX_W-1:0];
	assign last_issue = active_q && advance && (k_q == bgr_pkg::LAST_PIX);
	assign req_ready  = !active_q || last_issue;
	assign accept     = req_valid && req_ready;
	assign on_grid    = (int'(req.cell_col) < COLS) && (int'(req.cell_row) < ROWS);

	// Top-left pixel of the cell
	assign base = ADDR_W'(req.cell_row) * ROW_STRIDE + ADDR_W'({req.cell_col, 3'b000});

	// Control: load a cell on accept, drop off-grid cells, advance the pixel count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			k_q      <= '0;
		end else if (accept) begin
			active_q <= on_grid;
			k_q      <= '0;
		end else if (active_q && advance) begin
			k_q <= k_q + 1'b1;
			// go idle once the last pixel has left
			if (k_q == bgr_pkg::LAST_PIX) begin
				active_q <= 1'b0;
			end
		end
	end

	// Cell payload and line address
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q  <= bgr_pkg::glyph_index(req.char_code);
			fore_q <= req.fore_color;
			back_q <= req.back_color;
			line_q <= base;
		end else if (active_q && advance && cx == bgr_pkg::LAST_COL) begin
			line_q <= line_q + LINE_STEP;
		end
	end

	// Pixel issued this cycle
	always_comb begin
		issue.valid     = active_q;
		issue.glyph_idx = idx_q;
		issue.ry        = k_q[bgr_pkg::PIX_CNT_W-1:bgr_pkg::ROW_IDX_W];
		issue.cx        = cx;
		issue.addr      = line_q + ADDR_W'(cx);
		issue.fore      = fore_q;
		issue.back      = back_q;
		issue.last      = (k_q == bgr_pkg::LAST_PIX);
	end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bitmap_glyph_rasterizer: streams character cell words,
// paints each cell from its own font table and checks every pixel write.
// Depends on bgr_pkg for the cell and pixel word types.
module tb;

	localparam int SCREEN_W   = 320;
	localparam int SCREEN_H   = 240;
	localparam int GRID_COLS  = SCREEN_W / 8;
	localparam int GRID_ROWS  = SCREEN_H / 8;
	localparam int N_RANDOM   = 430;
	localparam int CYCLE_MAX  = 400000;
	localparam int HOLD_LEN   = 400;
	localparam int TAIL_WAIT  = 12;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	bgr_pkg::cell_req_t   req = '0;
	logic                 pix_valid;
	logic                 pix_ready = 1'b0;
	bgr_pkg::pixel_word_t pix;

	bgr_pkg::cell_req_t   cell_q[$];
	bgr_pkg::pixel_word_t pixel_exp_q[$];
	int          errors = 0;
	int          cells_sent = 0;
	int          pixels_seen = 0;
	int          hold_cnt = 0;
	int          next_hold_at = 3000;
	int          cycles = 0;

	// every code that has a glyph of its own
	string known_codes = " 0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ=-._:>";

	bitmap_glyph_rasterizer #(
		.SCREEN_WIDTH (SCREEN_W),
		.SCREEN_HEIGHT(SCREEN_H)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix      (pix)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Glyph bitmap per code, top row in the upper byte; anything unknown is blank
	function automatic logic [63:0] glyph_rows(input logic [7:0] code);
		case (code)
			"0": return 64'h7088_98A8_C888_7000;
			"1": return 64'h2060_2020_2020_7000;
			"2": return 64'h7088_1020_4080_F800;
			"3": return 64'h7088_0830_0888_7000;
			"4": return 64'h1030_5090_F810_1000;
			"5": return 64'hF880_F008_0888_7000;
			"6": return 64'h7080_80F0_8888_7000;
			"7": return 64'hF808_1020_4040_4000;
			"8": return 64'h7088_8870_8888_7000;
			"9": return 64'h7088_8878_0808_7000;
			"A": return 64'h7088_88F8_8888_8800;
			"B": return 64'hF088_88F0_8888_F000;
			"C": return 64'h7088_8080_8088_7000;
			"D": return 64'hF088_8888_8888_F000;
			"E": return 64'hF880_80F0_8080_F800;
			"F": return 64'hF880_80F0_8080_8000;
			"G": return 64'h7088_80B8_8888_7000;
			"H": return 64'h8888_88F8_8888_8800;
			"I": return 64'h7020_2020_2020_7000;
			"J": return 64'h3810_1010_1090_6000;
			"K": return 64'h8890_A0C0_A090_8800;
			"L": return 64'h8080_8080_8080_F800;
			"M": return 64'h88D8_A8A8_8888_8800;
			"N": return 64'h88C8_C8A8_9898_8800;
			"O": return 64'h7088_8888_8888_7000;
			"P": return 64'hF088_88F0_8080_8000;
			"Q": return 64'h7088_8888_A890_6800;
			"R": return 64'hF088_88F0_A090_8800;
			"S": return 64'h7088_8070_0888_7000;
			"T": return 64'hF820_2020_2020_2000;
			"U": return 64'h8888_8888_8888_7000;
			"V": return 64'h8888_8888_5050_2000;
			"W": return 64'h8888_88A8_A8A8_5000;
			"X": return 64'h8888_5020_5088_8800;
			"Y": return 64'h8888_5020_2020_2000;
			"Z": return 64'hF808_1020_4080_F800;
			"=": return 64'h0000_F800_F800_0000;
			"-": return 64'h0000_00F8_0000_0000;
			".": return 64'h0000_0000_0000_6000;
			"_": return 64'h0000_0000_0000_00F8;
			":": return 64'h0060_6000_6060_0000;
			">": return 64'h8040_2010_2040_8000;
			default: return 64'h0;
		endcase
	endfunction

	function automatic bgr_pkg::cell_req_t make_cell(input int col, input int row,
			input logic [7:0] code, input logic [15:0] fore, input logic [15:0] back);
		bgr_pkg::cell_req_t c;
		c.cell_col   = col[5:0];
		c.cell_row   = row[4:0];
		c.char_code  = code;
		c.fore_color = fore;
		c.back_color = back;
		return c;
	endfunction

	// Paint one accepted cell into the expected pixel stream
	task automatic queue_cell_pixels(input bgr_pkg::cell_req_t c);
		logic [63:0]          rows;
		bgr_pkg::pixel_word_t w;
		int          ry;
		int          cx;
		int          k;
		if (c.cell_col >= GRID_COLS || c.cell_row >= GRID_ROWS)
			return;
		rows = glyph_rows(c.char_code);
		for (ry = 0; ry < 8; ry++) begin
			for (cx = 0; cx < 8; cx++) begin
				k = ry * 8 + cx;
				w.pixel_addr  = 17'((c.cell_row * 8 + ry) * SCREEN_W + c.cell_col * 8 + cx);
				w.pixel_color = rows[63 - k] ? c.fore_color : c.back_color;
				w.last_pixel  = (k == 63);
				pixel_exp_q.push_back(w);
			end
		end
	endtask

	// Driver: offer queued cells, predict on acceptance, idle now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && req_ready) begin
				queue_cell_pixels(req);
				cells_sent++;
			end
			if (!req_valid || req_ready) begin
				if (cell_q.size() != 0 &&
						((cells_sent >= 200 && cells_sent < 300) || $urandom_range(99) >= 8)) begin
					req       <= cell_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each pixel write against the oldest expectation, drive ready
	always @(posedge clk or negedge arst_n) begin
		bgr_pkg::pixel_word_t exp_w;
		if (!arst_n) begin
			pix_ready <= 1'b0;
		end else begin
			if (pix_valid && pix_ready) begin
				pixels_seen++;
				if (pixel_exp_q.size() == 0) begin
					$display("%0t: unexpected pixel write addr=%0d color=%h last=%b",
						$time, pix.pixel_addr, pix.pixel_color, pix.last_pixel);
					errors++;
				end else begin
					exp_w = pixel_exp_q.pop_front();
					if (pix.pixel_addr !== exp_w.pixel_addr ||
							pix.pixel_color !== exp_w.pixel_color ||
							pix.last_pixel !== exp_w.last_pixel) begin
						$display({"%0t: pixel mismatch expected addr=%0d color=%h last=%b,",
							" got addr=%0d color=%h last=%b"},
							$time, exp_w.pixel_addr, exp_w.pixel_color, exp_w.last_pixel,
							pix.pixel_addr, pix.pixel_color, pix.last_pixel);
						errors++;
					end
				end
			end
			// hold off long enough to back the block up into its request port
			if (hold_cnt > 0) begin
				hold_cnt  <= hold_cnt - 1;
				pix_ready <= 1'b0;
			end else if (pixels_seen >= next_hold_at) begin
				hold_cnt     <= HOLD_LEN;
				next_hold_at <= next_hold_at + 12000;
				pix_ready    <= 1'b0;
			end else if (pixels_seen >= 6000 && pixels_seen < 10000) begin
				pix_ready <= 1'b1;
			end else begin
				pix_ready <= ($urandom_range(99) >= 8);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_MAX) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int          i;
		int          col;
		int          row;
		int          n_cells;
		logic [7:0]  code;

		// directed: grid corners, off-grid edges, unknown codes, color extremes
		cell_q.push_back(make_cell(0, 0, " ", 16'hFFFF, 16'h0000));
		cell_q.push_back(make_cell(GRID_COLS - 1, GRID_ROWS - 1, "A", 16'h0000, 16'hFFFF));
		cell_q.push_back(make_cell(GRID_COLS, 0, "0", 16'hFFFF, 16'h0000));
		cell_q.push_back(make_cell(63, 31, "Z", 16'hFFFF, 16'hFFFF));
		cell_q.push_back(make_cell(0, GRID_ROWS, "1", 16'h1234, 16'h4321));
		cell_q.push_back(make_cell(63, 0, "2", 16'h1111, 16'h2222));
		cell_q.push_back(make_cell(0, 31, "3", 16'h3333, 16'h4444));
		cell_q.push_back(make_cell(GRID_COLS - 1, 0, ">", 16'hF800, 16'h07E0));
		cell_q.push_back(make_cell(0, GRID_ROWS - 1, "_", 16'h001F, 16'hFFE0));
		cell_q.push_back(make_cell(5, 5, 8'h00, 16'hFFFF, 16'hA5A5));
		cell_q.push_back(make_cell(6, 7, 8'hFF, 16'hFFFF, 16'h5A5A));
		cell_q.push_back(make_cell(20, 15, 8'h7F, 16'hBEEF, 16'hCAFE));
		cell_q.push_back(make_cell(21, 15, "a", 16'hBEEF, 16'hCAFE));
		cell_q.push_back(make_cell(10, 3, "8", 16'hAAAA, 16'h5555));
		cell_q.push_back(make_cell(11, 3, "M", 16'h5555, 16'hAAAA));
		cell_q.push_back(make_cell(12, 3, "W", 16'h1234, 16'h1234));
		cell_q.push_back(make_cell(50, 2, "Q", 16'h0F0F, 16'hF0F0));
		cell_q.push_back(make_cell(13, 3, ":", 16'hF0F0, 16'h0F0F));
		cell_q.push_back(make_cell(14, 3, "=", 16'h8000, 16'h0001));

		// random: mostly on-grid cells of known glyphs, some off-grid and unknown codes
		for (i = 0; i < N_RANDOM; i++) begin
			col  = ($urandom_range(99) < 85) ? $urandom_range(GRID_COLS - 1) : $urandom_range(63);
			row  = ($urandom_range(99) < 85) ? $urandom_range(GRID_ROWS - 1) : $urandom_range(31);
			code = ($urandom_range(99) < 70) ? known_codes[$urandom_range(42)] :
				8'($urandom_range(255));
			cell_q.push_back(make_cell(col, row, code, 16'($urandom), 16'($urandom)));
		end
		n_cells = cell_q.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all cells accepted, all pixels back, then a short tail
		while (cells_sent < n_cells)
			@(posedge clk);
		while (pixel_exp_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
